@@ rtl/psid_pkg.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache package
// Shared widths, command codes, the slot RAM word and the control and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package psid_pkg;

  // Default table size.
  localparam int ENTRIES_DEF = 16;

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int GEN_W   = 32;
  localparam int STAMP_W = 32;
  localparam int TOT_W   = 32;
  localparam int META_W  = 17;

  // Message event codes.
  localparam logic [2:0] CMD_PREPARE  = 3'd0;
  localparam logic [2:0] CMD_REPLY    = 3'd1;
  localparam logic [2:0] CMD_CLOSE    = 3'd2;
  localparam logic [2:0] CMD_LOOKUP   = 3'd3;
  localparam logic [2:0] CMD_DROP_ALL = 3'd4;

  // Prepare reply body forms.
  localparam logic [1:0] FORM_EMPTY = 2'd0;
  localparam logic [1:0] FORM_ERROR = 2'd1;
  localparam logic [1:0] FORM_CUT   = 2'd2;
  localparam logic [1:0] FORM_OK    = 2'd3;

  // What the connection expects next.
  localparam logic [1:0] EXPECT_NONE  = 2'd0;
  localparam logic [1:0] EXPECT_REPLY = 2'd1;
  localparam logic [1:0] EXPECT_META  = 2'd2;

  // One slot as stored in the RAM.
  typedef struct packed {
    logic               truncated;
    logic [KEY_W-1:0]   key;
    logic [GEN_W-1:0]   gen;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted request
    logic rd_scan;    // read the slot at the scan address
    logic rd_target;  // read the chosen slot
    logic update;     // apply the request to the table and counters
    logic finish;     // load the result register
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // request must search the table
    logic is_drop;    // request is a drop-all
  } dp_stat_t;

endpackage

@@ rtl/psid_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/psid_ctrl.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache controller
// Sequences each request through dispatch, table scan or drop sweep, slot
// fetch, update and result hand-off.
// ----------------------------------------------------------------------------
module psid_ctrl import psid_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  dp_stat_t         stat,
  output dp_ctrl_t         ctrl,
  output logic [IDX_W-1:0] scan_addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SCAN_END,
    S_FETCH,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] scan_cnt;
  logic             out_free;

  // The result register can take a new result when empty or being drained.
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && !rst;
  assign scan_addr = scan_cnt;

  // Commands to the datapath decoded from the state.
  always_comb begin
    ctrl           = '0;
    ctrl.load      = (state == S_IDLE) && in_valid;
    ctrl.rd_scan   = (state == S_SCAN);
    ctrl.rd_target = (state == S_FETCH);
    ctrl.update    = (state == S_UPDATE);
    ctrl.finish    = (state == S_FINISH) && out_free;
  end

  // State, scan counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          scan_cnt <= '0;
          if (stat.need_scan || stat.is_drop) begin
            state <= S_SCAN;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_SCAN: begin
          if (scan_cnt == IDX_W'(ENTRIES - 1)) begin
            state <= S_SCAN_END;
          end else begin
            scan_cnt <= scan_cnt + IDX_W'(1);
          end
        end
        S_SCAN_END: begin
          if (stat.is_drop) begin
            state <= S_UPDATE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/psid_dp.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache datapath
// Holds the slot RAM, valid and written bits, pending entry, counters and
// the scan trackers that find the id, the first free slot and the oldest slot.
// ----------------------------------------------------------------------------
module psid_dp import psid_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W = $clog2(ENTRIES),
  localparam int OCC_W = $clog2(ENTRIES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_ctrl_t           ctrl,
  output dp_stat_t           stat,
  input  logic [IDX_W-1:0]   scan_addr,
  input  logic [2:0]         command,
  input  logic [KEY_W-1:0]   stmt_id,
  input  logic               id_present,
  input  logic [1:0]         reply_form,
  input  logic [15:0]        column_count,
  input  logic [15:0]        param_count,
  input  logic               capture_truncated,
  output logic               hit,
  output logic [3:0]         slot,
  output logic [GEN_W-1:0]   generation,
  output logic               entry_truncated,
  output logic [META_W-1:0]  metadata_left,
  output logic [1:0]         reply_expect,
  output logic               evicted,
  output logic               parse_error,
  output logic [4:0]         cached_count,
  output logic [TOT_W-1:0]   eviction_total,
  output logic [TOT_W-1:0]   parse_error_total
);

  // Latched request.
  logic [2:0]       cmd_q;
  logic [KEY_W-1:0] key_q;
  logic             idp_q;
  logic [1:0]       form_q;
  logic [15:0]      ncols_q;
  logic [15:0]      nparams_q;
  logic             ctrunc_q;

  // Table and connection state.
  logic [ENTRIES-1:0] valid_bits;
  logic [ENTRIES-1:0] written;
  logic [STAMP_W-1:0] use_clock;
  logic [OCC_W-1:0]   occupied;
  logic               pending_valid;
  logic               pending_truncated;
  logic [1:0]         expect_state;
  logic [TOT_W-1:0]   ev_total;
  logic [TOT_W-1:0]   perr_total;

  // Scan trackers.
  logic               take_q;
  logic [IDX_W-1:0]   rd_addr_q;
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   best_idx;
  logic [STAMP_W-1:0] best_stamp;

  // Result of the current request.
  logic               res_hit;
  logic [IDX_W-1:0]   res_slot;
  logic [GEN_W-1:0]   res_gen;
  logic               res_etrunc;
  logic [META_W-1:0]  res_meta;
  logic               res_ev;
  logic               res_perr;

  // RAM signals.
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_word;
  logic               wr_en;
  entry_t             wr_word;
  logic               sweep_wr;
  entry_t             sweep_word;

  // Update results.
  logic [IDX_W-1:0]   target_idx;
  logic [META_W-1:0]  meta_sum;
  logic               upd_wr;
  entry_t             upd_word;
  logic               pending_valid_next;
  logic               pending_truncated_next;
  logic [1:0]         expect_next;
  logic [STAMP_W-1:0] use_clock_next;
  logic [OCC_W-1:0]   occupied_next;
  logic [TOT_W-1:0]   ev_total_next;
  logic [TOT_W-1:0]   perr_total_next;
  logic [ENTRIES-1:0] valid_next;
  logic               hit_next;
  logic [IDX_W-1:0]   slot_next;
  logic [GEN_W-1:0]   gen_next;
  logic               etrunc_next;
  logic               ev_next;
  logic               perr_next;

  // Status toward the controller.
  always_comb begin
    stat.is_drop   = (cmd_q == CMD_DROP_ALL);
    stat.need_scan = ((cmd_q == CMD_REPLY) && (form_q == FORM_OK) && pending_valid) ||
                     ((cmd_q == CMD_CLOSE) && idp_q) ||
                     (cmd_q == CMD_LOOKUP);
  end

  // Slot that a reply binds: the id's own slot, else the first free, else the oldest.
  assign target_idx = match_found ? match_idx : (free_found ? free_idx : best_idx);
  assign meta_sum   = META_W'(ncols_q) + META_W'(nparams_q);

  // A slot never written reads as all zero.
  assign rd_en   = ctrl.rd_scan || ctrl.rd_target;
  assign rd_addr = ctrl.rd_target ? target_idx : scan_addr;
  assign rd_word = written[rd_addr_q] ? entry_t'(rd_data) : '0;

  // Drop-all sweep bumps the generation of each occupied slot.
  always_comb begin
    sweep_word     = rd_word;
    sweep_word.gen = rd_word.gen + GEN_W'(1);
    sweep_wr       = take_q && stat.is_drop && valid_bits[rd_addr_q];
  end

  assign wr_en   = sweep_wr || (ctrl.update && upd_wr);
  assign wr_word = sweep_wr ? sweep_word : upd_word;

  psid_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_addr_q),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Effect of the request on the table, counters and result.
  always_comb begin
    pending_valid_next     = pending_valid;
    pending_truncated_next = pending_truncated;
    expect_next            = expect_state;
    use_clock_next         = use_clock;
    occupied_next          = occupied;
    ev_total_next          = ev_total;
    perr_total_next        = perr_total;
    valid_next             = valid_bits;
    hit_next               = 1'b0;
    slot_next              = '0;
    gen_next               = '0;
    etrunc_next            = 1'b0;
    ev_next                = 1'b0;
    perr_next              = 1'b0;
    upd_wr                 = 1'b0;
    upd_word               = rd_word;

    unique case (cmd_q)
      CMD_PREPARE: begin
        pending_valid_next     = 1'b1;
        pending_truncated_next = ctrunc_q;
        expect_next            = EXPECT_REPLY;
      end
      CMD_REPLY: begin
        expect_next = EXPECT_NONE;
        if ((form_q == FORM_ERROR) || (form_q == FORM_CUT)) begin
          pending_valid_next = 1'b0;
          if ((form_q == FORM_CUT) && !ctrunc_q) begin
            perr_next       = 1'b1;
            perr_total_next = perr_total + TOT_W'(1);
          end
        end else if (form_q == FORM_OK) begin
          if (meta_sum != '0) begin
            expect_next = EXPECT_META;
          end
          if (pending_valid) begin
            pending_valid_next = 1'b0;
            if (!match_found) begin
              if (free_found) begin
                occupied_next = occupied + OCC_W'(1);
              end else begin
                ev_next       = 1'b1;
                ev_total_next = ev_total + TOT_W'(1);
              end
            end
            use_clock_next         = use_clock + STAMP_W'(1);
            valid_next[rd_addr_q]  = 1'b1;
            upd_wr                 = 1'b1;
            upd_word.truncated     = pending_truncated;
            upd_word.key           = key_q;
            upd_word.gen           = rd_word.gen + GEN_W'(1);
            upd_word.stamp         = use_clock + STAMP_W'(1);
            slot_next              = rd_addr_q;
          end
        end
      end
      CMD_CLOSE: begin
        if (idp_q && match_found) begin
          valid_next[rd_addr_q] = 1'b0;
          occupied_next         = occupied - OCC_W'(1);
          upd_wr                = 1'b1;
          upd_word.gen          = rd_word.gen + GEN_W'(1);
          hit_next              = 1'b1;
          slot_next             = rd_addr_q;
        end
      end
      CMD_LOOKUP: begin
        if (match_found) begin
          use_clock_next = use_clock + STAMP_W'(1);
          upd_wr         = 1'b1;
          upd_word.stamp = use_clock + STAMP_W'(1);
          hit_next       = 1'b1;
          slot_next      = rd_addr_q;
          gen_next       = rd_word.gen;
          etrunc_next    = rd_word.truncated;
        end
      end
      CMD_DROP_ALL: begin
        valid_next    = '0;
        occupied_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Request latch and scan trackers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q     <= command;
      key_q     <= stmt_id;
      idp_q     <= id_present;
      form_q    <= reply_form;
      ncols_q   <= column_count;
      nparams_q <= param_count;
      ctrunc_q  <= capture_truncated;
    end
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (take_q && !stat.is_drop) begin
      if (!match_found && valid_bits[rd_addr_q] && (rd_word.key == key_q)) begin
        match_idx <= rd_addr_q;
      end
      if (!free_found && !valid_bits[rd_addr_q]) begin
        free_idx <= rd_addr_q;
      end
      if ((rd_addr_q == '0) || (rd_word.stamp < best_stamp)) begin
        best_idx   <= rd_addr_q;
        best_stamp <= rd_word.stamp;
      end
    end
    if (ctrl.update) begin
      res_hit    <= hit_next;
      res_slot   <= slot_next;
      res_gen    <= gen_next;
      res_etrunc <= etrunc_next;
      res_meta   <= ((cmd_q == CMD_REPLY) && (form_q == FORM_OK)) ? meta_sum : '0;
      res_ev     <= ev_next;
      res_perr   <= perr_next;
    end
  end

  // Found flags and the table state proper.
  always_ff @(posedge clk) begin
    if (rst) begin
      take_q            <= 1'b0;
      match_found       <= 1'b0;
      free_found        <= 1'b0;
      valid_bits        <= '0;
      written           <= '0;
      use_clock         <= '0;
      occupied          <= '0;
      pending_valid     <= 1'b0;
      pending_truncated <= 1'b0;
      expect_state      <= EXPECT_NONE;
      ev_total          <= '0;
      perr_total        <= '0;
    end else begin
      take_q <= ctrl.rd_scan;
      if (ctrl.load) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end else if (take_q && !stat.is_drop) begin
        if (valid_bits[rd_addr_q] && (rd_word.key == key_q)) begin
          match_found <= 1'b1;
        end
        if (!valid_bits[rd_addr_q]) begin
          free_found <= 1'b1;
        end
      end
      if (ctrl.update) begin
        valid_bits        <= valid_next;
        use_clock         <= use_clock_next;
        occupied          <= occupied_next;
        pending_valid     <= pending_valid_next;
        pending_truncated <= pending_truncated_next;
        expect_state      <= expect_next;
        ev_total          <= ev_total_next;
        perr_total        <= perr_total_next;
        if (upd_wr) begin
          written[rd_addr_q] <= 1'b1;
        end
      end
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      hit               <= res_hit;
      slot              <= 4'(res_slot);
      generation        <= res_gen;
      entry_truncated   <= res_etrunc;
      metadata_left     <= res_meta;
      reply_expect      <= expect_state;
      evicted           <= res_ev;
      parse_error       <= res_perr;
      cached_count      <= 5'(occupied);
      eviction_total    <= ev_total;
      parse_error_total <= perr_total;
    end
  end

endmodule

@@ rtl/prepared_statement_id_cache.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache
// Fully associative table of statement ids with timestamp LRU replacement,
// per-slot generations, a pending prepare entry and running counters.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake            Carries
//   input     in_valid/in_ready    one parsed message event per request
//   output    out_valid/out_ready  one result per request
//
// A close with an id, a lookup and a reply that binds a pending entry scan the
// whole table before the slot fetch and update, and a drop-all sweeps it;
// the scan reads one slot of the slot RAM per cycle. Every other request goes
// straight from dispatch to update. The input reopens in the cycle after the result is loaded.
// Reset is synchronous and needs no clearing pass: per-slot written bits make
// untouched slots read as zero. A held result stalls only the final hand-off.
module prepared_statement_id_cache import psid_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        command,
  input  logic [KEY_W-1:0]  stmt_id,
  input  logic              id_present,
  input  logic [1:0]        reply_form,
  input  logic [15:0]       column_count,
  input  logic [15:0]       param_count,
  input  logic              capture_truncated,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [3:0]        slot,
  output logic [GEN_W-1:0]  generation,
  output logic              entry_truncated,
  output logic [META_W-1:0] metadata_left,
  output logic [1:0]        reply_expect,
  output logic              evicted,
  output logic              parse_error,
  output logic [4:0]        cached_count,
  output logic [TOT_W-1:0]  eviction_total,
  output logic [TOT_W-1:0]  parse_error_total
);

  dp_ctrl_t         ctrl;
  dp_stat_t         stat;
  logic [IDX_W-1:0] scan_addr;

  // Sequencer.
  psid_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl),
    .scan_addr (scan_addr)
  );

  // Table, counters and result register.
  psid_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .stat              (stat),
    .scan_addr         (scan_addr),
    .command           (command),
    .stmt_id           (stmt_id),
    .id_present        (id_present),
    .reply_form        (reply_form),
    .column_count      (column_count),
    .param_count       (param_count),
    .capture_truncated (capture_truncated),
    .hit               (hit),
    .slot              (slot),
    .generation        (generation),
    .entry_truncated   (entry_truncated),
    .metadata_left     (metadata_left),
    .reply_expect      (reply_expect),
    .evicted           (evicted),
    .parse_error       (parse_error),
    .cached_count      (cached_count),
    .eviction_total    (eviction_total),
    .parse_error_total (parse_error_total)
  );

endmodule

@@ rtl/psid_checker.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache checker
// Port-level properties of the cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
module psid_checker import psid_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              hit,
  input logic [3:0]        slot,
  input logic [META_W-1:0] metadata_left,
  input logic [1:0]        reply_expect,
  input logic              evicted,
  input logic              parse_error,
  input logic [4:0]        cached_count,
  input logic [TOT_W-1:0]  eviction_total
);

  // Only one request is in flight: an accepted request closes the input.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after a request was accepted");

  // An eviction only happens when every slot is occupied.
  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> cached_count == 5'(ENTRIES))
    else $error("eviction reported with free slots");

  // A hit comes from a close or lookup, which never evict or carry metadata.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted && !parse_error && metadata_left == '0)
    else $error("hit result carries reply fields");

  // A parse error ends any expectation of further replies.
  a_perr_expect: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_error |-> reply_expect == EXPECT_NONE)
    else $error("parse error left a reply expectation");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(eviction_total))
    else $error("stalled result changed");

endmodule

bind prepared_statement_id_cache psid_checker #(.ENTRIES(ENTRIES)) u_psid_checker (.*);

@@ test/prepared_statement_id_cache_test.sv @@
// ----------------------------------------------------------------------------
// Prepared statement id cache testbench
// Drives parsed message events into the cache through the request channel,
// predicts every result with a behavioral copy of the slot table, LRU clock,
// pending prepare entry and counters, and compares each returned result
// field by field. A directed opening covers empty tables, stray replies,
// every reply form, id reuse, close and drop-all. Well-formed prepare and
// reply pairs over a small id pool then fill the table and force evictions,
// mixed with lookups, closes and noise, under random idling on both sides.
// ----------------------------------------------------------------------------
module prepared_statement_id_cache_test;
  import psid_pkg::*;

  localparam int ENTRIES    = ENTRIES_DEF;
  localparam int CMD_SPACE  = 8;
  localparam int ITEM_GOAL  = 1650;
  localparam int POOL_SIZE  = 24;
  localparam int MAX_PAUSE  = 16;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = ENTRIES + 12;
  localparam int STALL_MAX  = 3000;
  localparam int REPORT_MAX = 10;

  // One parsed message event as it travels on the request channel.
  typedef struct packed {
    logic [2:0]       command;
    logic [KEY_W-1:0] stmt_id;
    logic             id_present;
    logic [1:0]       reply_form;
    logic [15:0]      column_count;
    logic [15:0]      param_count;
    logic             capture_truncated;
  } cache_event_t;

  // One result as returned on the output channel.
  typedef struct packed {
    logic              hit;
    logic [3:0]        slot;
    logic [GEN_W-1:0]  generation;
    logic              entry_truncated;
    logic [META_W-1:0] metadata_left;
    logic [1:0]        reply_expect;
    logic              evicted;
    logic              parse_error;
    logic [4:0]        cached_count;
    logic [TOT_W-1:0]  eviction_total;
    logic [TOT_W-1:0]  parse_error_total;
  } cache_result_t;

  // A queued request with the idle time the sender spends before it.
  typedef struct {
    cache_event_t ev;
    int unsigned  gap;
  } queued_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  cache_event_t offer = '0;

  logic [2:0]       command;
  logic [KEY_W-1:0] stmt_id;
  logic             id_present;
  logic [1:0]       reply_form;
  logic [15:0]      column_count;
  logic [15:0]      param_count;
  logic             capture_truncated;

  logic              in_ready;
  logic              out_valid;
  logic              hit;
  logic [3:0]        slot;
  logic [GEN_W-1:0]  generation;
  logic              entry_truncated;
  logic [META_W-1:0] metadata_left;
  logic [1:0]        reply_expect;
  logic              evicted;
  logic              parse_error;
  logic [4:0]        cached_count;
  logic [TOT_W-1:0]  eviction_total;
  logic [TOT_W-1:0]  parse_error_total;
  cache_result_t     seen;

  // Shadow of the cache table and its counters.
  logic               tbl_live  [ENTRIES] = '{default: 1'b0};
  logic [KEY_W-1:0]   tbl_key   [ENTRIES] = '{default: '0};
  logic [GEN_W-1:0]   tbl_gen   [ENTRIES] = '{default: '0};
  logic               tbl_trunc [ENTRIES] = '{default: 1'b0};
  logic [STAMP_W-1:0] tbl_stamp [ENTRIES] = '{default: '0};
  logic [STAMP_W-1:0] lru_clock = '0;
  int                 occ_count = 0;
  logic               pend_live = 1'b0;
  logic               pend_trunc = 1'b0;
  logic [1:0]         await_state = EXPECT_NONE;
  logic [TOT_W-1:0]   evict_count = '0;
  logic [TOT_W-1:0]   perr_count = '0;

  queued_event_t pending_events[$];
  cache_result_t predicted_results[$];
  logic [KEY_W-1:0] id_pool [POOL_SIZE];

  int unsigned send_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_pause = 0;
  int unsigned tx_mode = 1;
  int unsigned rx_mode = 1;
  int unsigned accepted_items = 0;
  int unsigned results_seen = 0;
  int unsigned total_items = 0;
  int unsigned real_items = 0;
  int unsigned stall_cycles = 0;
  int unsigned flaw_count = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned perrs_seen = 0;
  int unsigned long_holds = 0;

  always #5 clk = ~clk;

  assign {command, stmt_id, id_present, reply_form, column_count, param_count,
          capture_truncated} = offer;
  assign seen = {hit, slot, generation, entry_truncated, metadata_left, reply_expect,
                 evicted, parse_error, cached_count, eviction_total, parse_error_total};

  prepared_statement_id_cache u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .command           (command),
    .stmt_id           (stmt_id),
    .id_present        (id_present),
    .reply_form        (reply_form),
    .column_count      (column_count),
    .param_count       (param_count),
    .capture_truncated (capture_truncated),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hit               (hit),
    .slot              (slot),
    .generation        (generation),
    .entry_truncated   (entry_truncated),
    .metadata_left     (metadata_left),
    .reply_expect      (reply_expect),
    .evicted           (evicted),
    .parse_error       (parse_error),
    .cached_count      (cached_count),
    .eviction_total    (eviction_total),
    .parse_error_total (parse_error_total)
  );

  // Idle length for one request or result under the given pacing mode.
  function automatic int unsigned draw_pause(int unsigned mode);
    if (mode == 0) begin
      return 0;
    end
    if (mode == 1) begin
      return $urandom_range(0, MAX_PAUSE);
    end
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_PAUSE) : 0;
  endfunction

  // Slot that currently holds the given id, or -1.
  function automatic int find_id_slot(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_live[i] && tbl_key[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Apply one accepted request to the shadow table and return its result.
  function automatic cache_result_t apply_event(cache_event_t ev);
    cache_result_t r;
    int idx;
    logic [META_W-1:0] sum;
    r = '0;
    case (ev.command)
      CMD_PREPARE: begin
        pend_live = 1'b1;
        pend_trunc = ev.capture_truncated;
        await_state = EXPECT_REPLY;
      end
      CMD_REPLY: begin
        await_state = EXPECT_NONE;
        if (ev.reply_form == FORM_ERROR || ev.reply_form == FORM_CUT) begin
          // A cut ok head is a parse error unless capture loss explains it.
          if (ev.reply_form == FORM_CUT && !ev.capture_truncated) begin
            perr_count++;
            r.parse_error = 1'b1;
          end
          pend_live = 1'b0;
        end else if (ev.reply_form == FORM_OK) begin
          sum = META_W'(ev.column_count) + META_W'(ev.param_count);
          r.metadata_left = sum;
          if (sum != 0) begin
            await_state = EXPECT_META;
          end
          if (pend_live) begin
            pend_live = 1'b0;
            idx = find_id_slot(ev.stmt_id);
            // Same id first, then the lowest free slot, then the oldest stamp.
            if (idx < 0) begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (idx < 0 && !tbl_live[i]) begin
                  idx = i;
                end
              end
              if (idx >= 0) begin
                occ_count++;
              end else begin
                idx = 0;
                for (int i = 1; i < ENTRIES; i++) begin
                  if (tbl_stamp[i] < tbl_stamp[idx]) begin
                    idx = i;
                  end
                end
                evict_count++;
                r.evicted = 1'b1;
              end
            end
            tbl_live[idx] = 1'b1;
            tbl_trunc[idx] = pend_trunc;
            tbl_gen[idx]++;
            lru_clock++;
            tbl_stamp[idx] = lru_clock;
            tbl_key[idx] = ev.stmt_id;
            r.slot = idx[3:0];
          end
        end
      end
      CMD_CLOSE: begin
        idx = ev.id_present ? find_id_slot(ev.stmt_id) : -1;
        if (idx >= 0) begin
          tbl_live[idx] = 1'b0;
          tbl_gen[idx]++;
          occ_count--;
          r.hit = 1'b1;
          r.slot = idx[3:0];
        end
      end
      CMD_LOOKUP: begin
        idx = find_id_slot(ev.stmt_id);
        if (idx >= 0) begin
          lru_clock++;
          tbl_stamp[idx] = lru_clock;
          r.hit = 1'b1;
          r.slot = idx[3:0];
          r.generation = tbl_gen[idx];
          r.entry_truncated = tbl_trunc[idx];
        end
      end
      CMD_DROP_ALL: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_live[i]) begin
            tbl_live[i] = 1'b0;
            tbl_gen[i]++;
          end
        end
        occ_count = 0;
      end
      default: begin
      end
    endcase
    r.reply_expect = await_state;
    r.cached_count = occ_count[4:0];
    r.eviction_total = evict_count;
    r.parse_error_total = perr_count;
    return r;
  endfunction

  // Count one field mismatch and report it while under the report cap.
  function automatic void note_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      flaw_count++;
      if (flaw_count <= REPORT_MAX) begin
        $display("MISMATCH result %0d field %s: expected 0x%0h, got 0x%0h",
                 results_seen, name, want, got);
      end
    end
  endfunction

  // Compare one returned result with the oldest prediction.
  function automatic void check_result(cache_result_t got);
    cache_result_t want;
    if (predicted_results.size() == 0) begin
      flaw_count++;
      if (flaw_count <= REPORT_MAX) begin
        $display("MISMATCH result %0d arrived with no request outstanding", results_seen);
      end
      return;
    end
    want = predicted_results.pop_front();
    note_field("hit", 32'(want.hit), 32'(got.hit));
    note_field("slot", 32'(want.slot), 32'(got.slot));
    note_field("generation", want.generation, got.generation);
    note_field("entry_truncated", 32'(want.entry_truncated), 32'(got.entry_truncated));
    note_field("metadata_left", 32'(want.metadata_left), 32'(got.metadata_left));
    note_field("reply_expect", 32'(want.reply_expect), 32'(got.reply_expect));
    note_field("evicted", 32'(want.evicted), 32'(got.evicted));
    note_field("parse_error", 32'(want.parse_error), 32'(got.parse_error));
    note_field("cached_count", 32'(want.cached_count), 32'(got.cached_count));
    note_field("eviction_total", want.eviction_total, got.eviction_total);
    note_field("parse_error_total", want.parse_error_total, got.parse_error_total);
  endfunction

  // Request with every field random; callers override what matters.
  function automatic cache_event_t noise_event();
    cache_event_t e;
    e.command = 3'($urandom_range(0, CMD_SPACE - 1));
    e.stmt_id = $urandom;
    e.id_present = 1'($urandom);
    e.reply_form = 2'($urandom);
    e.column_count = 16'($urandom);
    e.param_count = 16'($urandom);
    e.capture_truncated = 1'($urandom);
    return e;
  endfunction

  function automatic cache_event_t make_event(logic [2:0] cmd, logic [KEY_W-1:0] key,
                                              logic idp, logic [1:0] form,
                                              logic [15:0] cols, logic [15:0] params,
                                              logic trunc);
    return '{cmd, key, idp, form, cols, params, trunc};
  endfunction

  function automatic void queue_event(cache_event_t e);
    queued_event_t q;
    q.ev = e;
    q.gap = draw_pause(tx_mode);
    pending_events.push_back(q);
    if (e.command <= CMD_DROP_ALL) begin
      real_items++;
    end
  endfunction

  function automatic logic [KEY_W-1:0] pick_id();
    return ($urandom_range(0, 6) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // A well-formed prepare followed by its reply.
  function automatic void queue_prepare_pair();
    cache_event_t e;
    int unsigned pick;
    e = noise_event();
    e.command = CMD_PREPARE;
    e.capture_truncated = ($urandom_range(0, 6) == 0);
    queue_event(e);
    e = noise_event();
    e.command = CMD_REPLY;
    e.stmt_id = pick_id();
    e.capture_truncated = ($urandom_range(0, 6) == 0);
    pick = $urandom_range(0, 99);
    e.reply_form = (pick < 80) ? FORM_OK : (pick < 87) ? FORM_EMPTY :
                   (pick < 94) ? FORM_ERROR : FORM_CUT;
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      e.column_count = '0;
      e.param_count = '0;
    end else if (pick < 17) begin
      e.column_count = 16'($urandom_range(0, 3));
      e.param_count = 16'($urandom_range(0, 3));
    end
    queue_event(e);
  endfunction

  // Request driver: one request offered at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else if (in_valid && in_ready) begin
      predicted_results.push_back(apply_event(offer));
      accepted_items++;
      if (pending_events.size() != 0 && pending_events[0].gap == 0) begin
        offer <= pending_events.pop_front().ev;
      end else begin
        in_valid <= 1'b0;
        send_wait <= (pending_events.size() != 0) ? pending_events[0].gap - 1 : 0;
      end
    end else if (!in_valid) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_events.size() != 0) begin
        offer <= pending_events.pop_front().ev;
        in_valid <= 1'b1;
      end
    end
  end

  // Result monitor: checks each result and paces the ready line.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && out_ready) begin
      check_result(seen);
      results_seen++;
      hits_seen += seen.hit;
      evictions_seen += seen.evicted;
      perrs_seen += seen.parse_error;
      if (results_seen % 64 == 0) begin
        rx_mode = $urandom_range(0, 2);
      end
      // Two long hold-offs stall the result side and with it the request side.
      if (results_seen == 300 || results_seen == 1100) begin
        rx_pause = LONG_HOLD;
        long_holds++;
      end else begin
        rx_pause = draw_pause(rx_mode);
      end
      if (rx_pause != 0) begin
        out_ready <= 1'b0;
        rx_wait <= rx_pause - 1;
      end
    end else if (!out_ready) begin
      if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Timeout after %0d cycles without progress", stall_cycles);
      $display("prepared_statement_id_cache_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    cache_event_t e;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      id_pool[i] = $urandom;
    end

    // Directed opening on an empty table.
    tx_mode = 1;
    queue_event(make_event(CMD_LOOKUP, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_CLOSE, '1, 1'b0, FORM_OK, '1, '1, 1'b1));
    // Complete reply with nothing pending and the largest metadata counts.
    queue_event(make_event(CMD_REPLY, 32'h1234_5678, 1'b1, FORM_OK, '1, '1, 1'b0));
    // Prepare captured truncated, then bind the all-ones id.
    queue_event(make_event(CMD_PREPARE, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b1));
    queue_event(make_event(CMD_REPLY, '1, 1'b0, FORM_OK, '0, '0, 1'b0));
    queue_event(make_event(CMD_LOOKUP, '1, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    // An empty reply keeps the pending entry for the next complete reply.
    queue_event(make_event(CMD_PREPARE, '1, 1'b1, FORM_OK, '1, '1, 1'b0));
    queue_event(make_event(CMD_REPLY, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, '0, 1'b0, FORM_OK, 16'd1, '0, 1'b0));
    // An error reply drops the pending entry.
    queue_event(make_event(CMD_PREPARE, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd5, 1'b0, FORM_ERROR, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd5, 1'b0, FORM_OK, '0, 16'd1, 1'b0));
    // A cut ok head: parse error without capture loss, none with it.
    queue_event(make_event(CMD_PREPARE, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd7, 1'b0, FORM_CUT, '0, '0, 1'b0));
    queue_event(make_event(CMD_PREPARE, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, 32'd7, 1'b0, FORM_CUT, '0, '0, 1'b1));
    // Binding an id that is already cached reuses its slot.
    queue_event(make_event(CMD_PREPARE, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_REPLY, '1, 1'b0, FORM_OK, '0, '0, 1'b0));
    // Close of a known id, then of an unknown one.
    queue_event(make_event(CMD_CLOSE, '1, 1'b1, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_CLOSE, 32'hDEAD_BEEF, 1'b1, FORM_EMPTY, '0, '0, 1'b0));
    // Unused command codes are ignored.
    for (int c = CMD_DROP_ALL + 1; c < CMD_SPACE; c++) begin
      queue_event(make_event(3'(c), '1, 1'b1, FORM_OK, '1, '1, 1'b1));
    end
    queue_event(make_event(CMD_DROP_ALL, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));
    queue_event(make_event(CMD_LOOKUP, '0, 1'b0, FORM_EMPTY, '0, '0, 1'b0));

    // Random part, paced in blocks of changing sender behavior.
    while (real_items < ITEM_GOAL) begin
      int unsigned pick;
      if (real_items % 100 < 2) begin
        tx_mode = $urandom_range(0, 2);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_prepare_pair();
      end else if (pick < 70) begin
        e = noise_event();
        e.command = CMD_LOOKUP;
        e.stmt_id = pick_id();
        queue_event(e);
      end else if (pick < 80) begin
        e = noise_event();
        e.command = CMD_CLOSE;
        e.stmt_id = pick_id();
        e.id_present = ($urandom_range(0, 9) != 0);
        queue_event(e);
      end else if (pick < 82) begin
        e = noise_event();
        e.command = CMD_DROP_ALL;
        queue_event(e);
      end else if (pick < 88) begin
        e = noise_event();
        e.command = CMD_REPLY;
        e.stmt_id = pick_id();
        queue_event(e);
      end else if (pick < 92) begin
        e = noise_event();
        e.command = CMD_PREPARE;
        queue_event(e);
      end else begin
        queue_event(noise_event());
      end
    end
    total_items = pending_events.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_items != total_items || predicted_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    if (predicted_results.size() != 0) begin
      flaw_count += predicted_results.size();
      $display("%0d predicted results never arrived", predicted_results.size());
    end
    $display("Checked %0d results from %0d requests: %0d hits, %0d evictions,",
             results_seen, accepted_items, hits_seen, evictions_seen);
    $display("%0d parse errors, %0d long output hold-offs; %0d mismatches.",
             perrs_seen, long_holds, flaw_count);
    if (flaw_count == 0) begin
      $display("prepared_statement_id_cache_test: done, clean");
    end else begin
      $display("prepared_statement_id_cache_test: done, errors");
    end
    $finish;
  end

endmodule

@@ prepared_statement_id_cache.f @@
rtl/psid_pkg.sv
rtl/psid_ram.sv
rtl/psid_ctrl.sv
rtl/psid_dp.sv
rtl/prepared_statement_id_cache.sv
rtl/psid_checker.sv
test/prepared_statement_id_cache_test.sv
